// ===== rtl/speck_pkg.sv =====
// ---------------------------------------------------------------------------
// speck_pkg - shared types and helpers for the speck 64/128 core
// word type, key register indexes and the rotate helpers of the round
// ---------------------------------------------------------------------------
package speck_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_KEYS  = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [WORD_W-1:0] word_t;

  // key register indexes
  localparam logic [CFG_IDX_W-1:0] KEY_WORD0_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD1_IDX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD2_IDX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD3_IDX = 2'd3;

  // one block in flight: direction flag plus the two block words
  typedef struct packed {
    logic  dec;
    word_t x;
    word_t y;
  } blk_t;

  function automatic word_t ror8(input word_t v);
    return {v[7:0], v[31:8]};
  endfunction

  function automatic word_t rol8(input word_t v);
    return {v[23:0], v[31:24]};
  endfunction

  function automatic word_t ror3(input word_t v);
    return {v[2:0], v[31:3]};
  endfunction

  function automatic word_t rol3(input word_t v);
    return {v[28:0], v[31:29]};
  endfunction

endpackage

// ===== rtl/speck64_128_block_cipher.sv =====
// ---------------------------------------------------------------------------
// speck64_128_block_cipher - pipelined speck 64/128 block cipher
// one round per cell, encrypt or decrypt chosen per word
// ---------------------------------------------------------------------------
// usage:
//   key words are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   the core is idle. every write restarts the round key expansion, which
//   builds all NUM_ROUNDS round keys (27 by default); the input side holds
//   s_axis_tready low until it ends. reset loads the all-zero key and runs
//   the same expansion before the first word is taken.
//   s_axis_tuser selects encrypt (0) or decrypt (1); s_axis_tdata carries
//   the block. the result appears on m_axis with the same word order.
//   each block passes through the chain of NUM_ROUNDS round cells, each a
//   registered stage, from the input handshake to m_axis_tvalid.
//   throughput: one block per cycle outside key expansion. when the receiver
//   stalls, the cells fill up behind the last one; each cell moves on as soon
//   as its neighbour has room, so input is taken until the whole chain is full.
// ---------------------------------------------------------------------------
module speck64_128_block_cipher #(
  parameter int unsigned NUM_ROUNDS = 27
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // key register write port
  input  logic                             cfg_we_i,
  input  logic [speck_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                      cfg_wdata_i,
  // input words
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [63:0]                      s_axis_tdata,  // block_lo, block_hi
  input  logic                             s_axis_tuser,  // req_type
  // result words
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [63:0]                      m_axis_tdata   // out_lo, out_hi
);

  logic                               busy;
  speck_pkg::word_t [NUM_ROUNDS-1:0]  rk;
  logic             [NUM_ROUNDS:0]    vld;
  logic             [NUM_ROUNDS:0]    rdy;
  speck_pkg::blk_t  [NUM_ROUNDS:0]    blk;

  // key expansion
  speck_key_sched #(
    .NUM_ROUNDS (NUM_ROUNDS)
  ) u_key_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (busy),
    .rk_o        (rk)
  );

  // chain input
  assign vld[0]     = s_axis_tvalid && !busy;
  assign blk[0].dec = s_axis_tuser;
  assign blk[0].y   = s_axis_tdata[31:0];
  assign blk[0].x   = s_axis_tdata[63:32];
  assign s_axis_tready = rdy[0] && !busy;

  // round cells; decryption walks the key table backwards
  for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_cell
    speck_round_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .enc_key_i   (rk[i]),
      .dec_key_i   (rk[NUM_ROUNDS-1-i]),
      .in_valid_i  (vld[i]),
      .in_ready_o  (rdy[i]),
      .in_blk_i    (blk[i]),
      .out_valid_o (vld[i+1]),
      .out_ready_i (rdy[i+1]),
      .out_blk_o   (blk[i+1])
    );
  end

  // chain output
  assign rdy[NUM_ROUNDS] = m_axis_tready;
  assign m_axis_tvalid   = vld[NUM_ROUNDS];
  assign m_axis_tdata    = {blk[NUM_ROUNDS].x, blk[NUM_ROUNDS].y};

  // no block enters while round keys are being rebuilt
  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("input taken during key expansion");

  // a key write always starts an expansion pass
  a_write_starts_exp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("key write did not start expansion");

  // an accepted block lands in the first cell
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld[1])
    else $error("accepted block lost at first cell");

endmodule

// ===== rtl/speck_key_sched.sv =====
// ---------------------------------------------------------------------------
// speck_key_sched - key registers and round key expansion
// holds the four key words and builds the round key table one key per cycle
// ---------------------------------------------------------------------------
module speck_key_sched #(
  parameter int unsigned NUM_ROUNDS = 27
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [speck_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  speck_pkg::word_t                   cfg_wdata_i,
  output logic                               busy_o,
  output speck_pkg::word_t [NUM_ROUNDS-1:0]  rk_o
);

  localparam int unsigned CW = $clog2(NUM_ROUNDS + 1);
  localparam int unsigned IW = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;

  speck_pkg::word_t [speck_pkg::NUM_KEYS-1:0] key_q, key_d;
  speck_pkg::word_t                           k_q, k_d;
  speck_pkg::word_t [2:0]                     l_q, l_d;
  logic [CW-1:0]                              cnt_q, cnt_d;
  logic                                       busy_q, busy_d;
  speck_pkg::word_t [NUM_ROUNDS-1:0]          rk_q;
  speck_pkg::word_t                           l_new, rnd_idx;

  // schedule round with the step count as key
  assign rnd_idx = {{(speck_pkg::WORD_W - CW){1'b0}}, cnt_q};
  assign l_new   = (speck_pkg::ror8(l_q[0]) + k_q) ^ rnd_idx;

  // key register write merge
  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        speck_pkg::KEY_WORD0_IDX: key_d[0] = cfg_wdata_i;
        speck_pkg::KEY_WORD1_IDX: key_d[1] = cfg_wdata_i;
        speck_pkg::KEY_WORD2_IDX: key_d[2] = cfg_wdata_i;
        speck_pkg::KEY_WORD3_IDX: key_d[3] = cfg_wdata_i;
        default: key_d = key_q;
      endcase
    end
  end

  // expansion sequencer: a write restarts the pass from the new key
  always_comb begin
    k_d    = k_q;
    l_d    = l_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (cfg_we_i) begin
      k_d    = key_d[0];
      l_d    = {key_d[3], key_d[2], key_d[1]};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      k_d    = speck_pkg::rol3(k_q) ^ l_new;
      l_d    = {l_new, l_q[2], l_q[1]};
      cnt_d  = cnt_q + 1'b1;
      busy_d = (cnt_q != CW'(NUM_ROUNDS - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      k_q    <= '0;
      l_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      key_q  <= key_d;
      k_q    <= k_d;
      l_q    <= l_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  // round key table, one entry written per expansion step
  always_ff @(posedge clk_i) begin
    if (busy_q && !cfg_we_i) begin
      rk_q[cnt_q[IW-1:0]] <= k_q;
    end
  end

  assign busy_o = busy_q;
  assign rk_o   = rk_q;

endmodule

// ===== rtl/speck_round_cell.sv =====
// ---------------------------------------------------------------------------
// speck_round_cell - one cipher round with its own block register
// applies an encrypt or decrypt round and passes the block to the next cell
// ---------------------------------------------------------------------------
module speck_round_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  speck_pkg::word_t  enc_key_i,
  input  speck_pkg::word_t  dec_key_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  speck_pkg::blk_t   in_blk_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output speck_pkg::blk_t   out_blk_o
);

  logic              vld_q;
  speck_pkg::blk_t   blk_q, blk_d;
  speck_pkg::word_t  enc_x, enc_y, dec_x, dec_y;

  // forward round
  assign enc_x = (speck_pkg::ror8(in_blk_i.x) + in_blk_i.y) ^ enc_key_i;
  assign enc_y = speck_pkg::rol3(in_blk_i.y) ^ enc_x;

  // inverse round
  assign dec_y = speck_pkg::ror3(in_blk_i.y ^ in_blk_i.x);
  assign dec_x = speck_pkg::rol8((in_blk_i.x ^ dec_key_i) - dec_y);

  always_comb begin
    blk_d.dec = in_blk_i.dec;
    blk_d.x   = in_blk_i.dec ? dec_x : enc_x;
    blk_d.y   = in_blk_i.dec ? dec_y : enc_y;
  end

  // cell takes a new word when empty or when its contents move on
  assign in_ready_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_blk_o   = blk_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top - testbench for the speck 64/128 block cipher
// drives blocks in both directions under several key settings, with bursty
// input and a stalling receiver, and compares every result word with a
// cipher predictor kept in a small scoreboard class
// ---------------------------------------------------------------------------

// expected words of one processed block
typedef struct packed {
  speck_pkg::word_t hi;
  speck_pkg::word_t lo;
} block_words_t;

// key schedule, cipher predictor and store of expected blocks
class cipher_scoreboard;
  localparam int unsigned ROUNDS = 27;

  speck_pkg::word_t key_regs[speck_pkg::NUM_KEYS];
  speck_pkg::word_t sched_keys[ROUNDS];
  block_words_t     expected_blocks[$];
  int unsigned      n_errors;
  int unsigned      n_results;
  int unsigned      n_enc;
  int unsigned      n_dec;

  function new();
    foreach (key_regs[i]) key_regs[i] = '0;
    n_errors  = 0;
    n_results = 0;
    n_enc     = 0;
    n_dec     = 0;
    expand_schedule();
  endfunction

  function speck_pkg::word_t rot_right(speck_pkg::word_t v, int unsigned s);
    return (v >> s) | (v << (speck_pkg::WORD_W - s));
  endfunction

  function speck_pkg::word_t rot_left(speck_pkg::word_t v, int unsigned s);
    return (v << s) | (v >> (speck_pkg::WORD_W - s));
  endfunction

  // round keys from the four key words, round index as key
  function void expand_schedule();
    speck_pkg::word_t w[speck_pkg::NUM_KEYS];
    int unsigned      sel;
    sel = 0;
    foreach (w[i]) w[i] = key_regs[i];
    for (int unsigned r = 0; r < ROUNDS; r++) begin
      sched_keys[r] = w[0];
      sel++;
      if (sel > 3) sel = 1;
      w[sel] = (rot_right(w[sel], 8) + w[0]) ^ speck_pkg::word_t'(r);
      w[0]   = rot_left(w[0], 3) ^ w[sel];
    end
  endfunction

  function void set_key(int unsigned idx, speck_pkg::word_t value);
    key_regs[idx] = value;
    expand_schedule();
  endfunction

  // x is the high word, y the low word
  function block_words_t run_cipher(bit dec, speck_pkg::word_t lo, speck_pkg::word_t hi);
    block_words_t     res;
    speck_pkg::word_t x;
    speck_pkg::word_t y;
    x = hi;
    y = lo;
    if (!dec) begin
      for (int r = 0; r < ROUNDS; r++) begin
        x = (rot_right(x, 8) + y) ^ sched_keys[r];
        y = rot_left(y, 3) ^ x;
      end
    end else begin
      for (int r = ROUNDS - 1; r >= 0; r--) begin
        y = rot_right(y ^ x, 3);
        x = rot_left((x ^ sched_keys[r]) - y, 8);
      end
    end
    res.lo = y;
    res.hi = x;
    return res;
  endfunction

  function void note_input(bit dec, speck_pkg::word_t lo, speck_pkg::word_t hi);
    expected_blocks.push_back(run_cipher(dec, lo, hi));
    if (dec) n_dec++;
    else n_enc++;
  endfunction

  function void check_result(speck_pkg::word_t lo, speck_pkg::word_t hi);
    block_words_t exp_blk;
    n_results++;
    if (expected_blocks.size() == 0) begin
      $error("unexpected result word: out_lo=%h out_hi=%h", lo, hi);
      n_errors++;
    end else begin
      exp_blk = expected_blocks.pop_front();
      if (lo !== exp_blk.lo) begin
        $error("out_lo mismatch: expected %h, actual %h", exp_blk.lo, lo);
        n_errors++;
      end
      if (hi !== exp_blk.hi) begin
        $error("out_hi mismatch: expected %h, actual %h", exp_blk.hi, hi);
        n_errors++;
      end
    end
  endfunction

  function int unsigned pending();
    return expected_blocks.size();
  endfunction
endclass

module tb_top;

  localparam int unsigned NUM_ROUNDS     = 27;
  localparam bit          DIR_ENC        = 1'b0;
  localparam bit          DIR_DEC        = 1'b1;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned ITEMS_PER_PHASE = 92;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [speck_pkg::CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [31:0]                     cfg_wdata_i   = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [63:0]                     s_axis_tdata  = '0;  // block_lo, block_hi
  logic                            s_axis_tuser  = 1'b0;  // req_type
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [63:0]                     m_axis_tdata;  // out_lo, out_hi

  cipher_scoreboard sb;
  int unsigned      burst_left = 0;
  int unsigned      key_settings = 0;

  speck64_128_block_cipher #(
    .NUM_ROUNDS(NUM_ROUNDS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // result monitor and receiver stall pattern
  int unsigned run_left = 0;
  bit          run_ready = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[31:0], m_axis_tdata[63:32]);
    end
    if (run_left == 0) begin
      run_ready = ~run_ready;
      if (run_ready) run_left = $urandom_range(1, 40);
      else if ($urandom_range(0, 2) == 0) run_left = 0;
      else if ($urandom_range(0, 5) == 0) run_left = $urandom_range(13, 30);
      else run_left = $urandom_range(1, 12);
    end
    if (run_left != 0) begin
      run_left--;
      m_axis_tready <= run_ready;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // mostly random words, with corner values now and then
  function automatic speck_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return speck_pkg::word_t'(1) << $urandom_range(0, 31);
      3:       return ~(speck_pkg::word_t'(1) << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // one block word, sent in bursts with random gaps in between
  task automatic send_block(input bit dec, input speck_pkg::word_t lo,
                            input speck_pkg::word_t hi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= dec;
    s_axis_tdata  <= {hi, lo};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(dec, lo, hi);
  endtask

  // stop sending and wait for every expected block
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [speck_pkg::CFG_IDX_W-1:0] idx,
                           input speck_pkg::word_t value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_key(idx, value);
  endtask

  task automatic end_key_writes();
    cfg_we_i <= 1'b0;
    key_settings++;
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_key_set(input speck_pkg::word_t k0, input speck_pkg::word_t k1,
                               input speck_pkg::word_t k2, input speck_pkg::word_t k3);
    write_key(speck_pkg::KEY_WORD0_IDX, k0);
    write_key(speck_pkg::KEY_WORD1_IDX, k1);
    write_key(speck_pkg::KEY_WORD2_IDX, k2);
    write_key(speck_pkg::KEY_WORD3_IDX, k3);
    end_key_writes();
  endtask

  // main sequence
  initial begin
    speck_pkg::word_t                corner_lo[7];
    speck_pkg::word_t                corner_hi[7];
    block_words_t                    ct;
    speck_pkg::word_t                lo;
    speck_pkg::word_t                hi;
    logic [speck_pkg::CFG_IDX_W-1:0] single_idx;
    int unsigned                     sent;
    int unsigned                     waited;

    sb = new();
    corner_lo = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h5555_5555};
    corner_hi = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000,
                  32'h0000_0001, 32'hffff_fffe, 32'haaaa_aaaa};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner blocks both ways under the all-zero key from reset
    for (int i = 0; i < 7; i++) begin
      send_block(DIR_ENC, corner_lo[i], corner_hi[i]);
      send_block(DIR_DEC, corner_lo[i], corner_hi[i]);
    end
    drain_results();

    // published test vector key and block, then its ciphertext back
    write_key_set(32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'h1b1a_1918);
    send_block(DIR_ENC, 32'h7475_432d, 32'h3b72_6574);
    send_block(DIR_DEC, 32'h454e_028b, 32'h8c6f_a548);
    drain_results();

    // random phases, each under its own key setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_key_set('1, '1, '1, '1);
        1, 5: write_key_set($urandom, $urandom, $urandom, $urandom);
        2, 6: begin
          // only one key word changes, the schedule is rebuilt from all four
          single_idx = $urandom_range(0, 3);
          write_key(single_idx, $urandom);
          end_key_writes();
        end
        3: write_key_set('0, '0, '0, '0);
        4: write_key_set(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
        default: write_key_set(32'h8000_0000, 32'h0000_0001, '1, '0);
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        lo = pick_word();
        hi = pick_word();
        if ($urandom_range(0, 3) == 0) begin
          // encrypt then decrypt its ciphertext
          ct = sb.run_cipher(DIR_ENC, lo, hi);
          send_block(DIR_ENC, lo, hi);
          send_block(DIR_DEC, ct.lo, ct.hi);
          sent += 2;
        end else begin
          send_block(bit'($urandom_range(0, 1)), lo, hi);
          sent++;
        end
      end
      if (ph != NUM_PHASES - 1) drain_results();
    end

    // wait for the pipeline to empty, then a little longer
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (NUM_ROUNDS + 8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected blocks never arrived", sb.pending());
      sb.n_errors++;
    end

    $display("sent %0d encrypt and %0d decrypt blocks under %0d key settings",
             sb.n_enc, sb.n_dec, key_settings + 1);
    $display("checked %0d result words, %0d mismatches", sb.n_results, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/speck_pkg.sv
rtl/speck_key_sched.sv
rtl/speck_round_cell.sv
rtl/speck64_128_block_cipher.sv
tb/tb_top.sv
